[hw/rtl/tef_pkg.sv]
package tef_pkg;

  // Parser states; codes 6 and 7 are unused and behave as ground.
  typedef enum logic [2:0] {
    ST_GROUND  = 3'd0,
    ST_ESC     = 3'd1,
    ST_ESC_INT = 3'd2,
    ST_CSI     = 3'd3,
    ST_OSC     = 3'd4,
    ST_OSC_ST  = 3'd5
  } parse_state_e;

  // Item kinds
  localparam logic KindData  = 1'b0;
  localparam logic KindFlush = 1'b1;

  // Byte codes
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChIntHi = 8'h2F;
  localparam logic [7:0] ChFinLo = 8'h30;
  localparam logic [7:0] ChCsiLo = 8'h40;
  localparam logic [7:0] ChCsi   = 8'h5B;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChOsc   = 8'h5D;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChHigh  = 8'h80;

  // Output queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = 2;
  localparam int unsigned CntW      = 3;

  // Words produced by one item: up to two, the last one flagged downstream.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_t;

endpackage

[hw/rtl/tef_parser.sv]
module tef_parser (
  input  logic                  kind_i,
  input  logic [7:0]            byte_i,
  input  tef_pkg::parse_state_e state_i,
  input  logic                  pend_cr_i,
  output tef_pkg::parse_state_e state_o,
  output logic                  pend_cr_o,
  output tef_pkg::res_t         res_o
);
  import tef_pkg::*;

  logic       printable;
  logic       inter;
  logic       fin;
  logic       csi_fin;
  logic       csi_bad;
  logic       gnd;
  logic [1:0] n;

  assign printable = (byte_i >= ChSpace) && (byte_i <= ChTilde);
  assign inter     = (byte_i >= ChSpace) && (byte_i <= ChIntHi);
  assign fin       = (byte_i >= ChFinLo) && (byte_i <= ChTilde);
  assign csi_fin   = (byte_i >= ChCsiLo) && (byte_i <= ChTilde);
  assign csi_bad   = (byte_i < ChSpace) || (byte_i == ChDel) || (byte_i >= ChHigh);

  always_comb begin
    state_o   = state_i;
    pend_cr_o = pend_cr_i;
    res_o     = '0;
    gnd       = 1'b0;
    n         = 2'd0;
    if (kind_i == KindFlush) begin
      res_o.cnt = {1'b0, pend_cr_i};
      res_o.b0  = ChLf;
      state_o   = ST_GROUND;
      pend_cr_o = 1'b0;
    end else begin
      if (pend_cr_i) begin
        pend_cr_o = 1'b0;
        res_o.b0  = ChLf;
        n         = 2'd1;
      end
      // CR LF collapses to the single LF already emitted
      if (!(pend_cr_i && (byte_i == ChLf))) begin
        case (state_i)
          ST_ESC: begin
            state_o = ST_GROUND;
            if (byte_i == ChCsi)      state_o = ST_CSI;
            else if (byte_i == ChOsc) state_o = ST_OSC;
            else if (inter)           state_o = ST_ESC_INT;
            else if (!fin)            gnd = 1'b1;
          end
          ST_ESC_INT: begin
            if (fin)         state_o = ST_GROUND;
            else if (!inter) begin
              state_o = ST_GROUND;
              gnd     = 1'b1;
            end
          end
          ST_CSI: begin
            if (csi_fin) state_o = ST_GROUND;
            else if (csi_bad) begin
              state_o = ST_GROUND;
              gnd     = 1'b1;
            end
          end
          ST_OSC: begin
            if (byte_i == ChBel)      state_o = ST_GROUND;
            else if (byte_i == ChEsc) state_o = ST_OSC_ST;
          end
          ST_OSC_ST: begin
            state_o = ST_GROUND;
            gnd     = (byte_i != ChBslash);
          end
          default: begin
            state_o = ST_GROUND;
            gnd     = 1'b1;
          end
        endcase
        // ground handling, also for a byte that broke off a sequence
        if (gnd) begin
          if (byte_i == ChCr) begin
            pend_cr_o = 1'b1;
          end else if (byte_i == ChEsc) begin
            state_o = ST_ESC;
          end else if ((byte_i == ChLf) || (byte_i == ChTab) || printable ||
                       (byte_i >= ChHigh)) begin
            if (n == 2'd0) res_o.b0 = byte_i;
            else           res_o.b1 = byte_i;
            n = n + 2'd1;
          end
        end
      end
      res_o.cnt = n;
    end
  end

endmodule

[hw/rtl/tef_out_fifo.sv]
module tef_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tef_pkg::res_t push_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    byte_out_o,
  output logic          last_o
);
  import tef_pkg::*;

  logic [8:0]      mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_nxt;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign room_o      = (cnt_q <= CntW'(FifoDepth - 2));
  assign byte_out_o  = mem_q[rd_q][8:1];
  assign last_o      = mem_q[rd_q][0];
  assign wr_nxt      = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.cnt);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= {push_i.b0, push_i.cnt == 2'd1};
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= {push_i.b1, 1'b1};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("output queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (CntW'(push_i.cnt) <= CntW'(FifoDepth) - cnt_q))
    else $error("push into a full output queue");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_i.cnt == 2'd0)) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("queue count not decremented on pop");

endmodule

[hw/rtl/terminal_escape_filter_top.sv]
// Terminal escape filter. Takes terminal output one word (byte) at a time and
// passes printable characters, TAB, LF and bytes of 0x80 upward, while it
// strips ANSI escape sequences (plain ESC with intermediates, CSI, and OSC
// ended by BEL or ESC backslash) and other control bytes. CR is turned into
// LF and CR LF gives one LF; a byte that breaks off a sequence is treated
// afresh as an ordinary byte. A flush word (kind_i = 1) emits any pending LF
// and resets the parser. Each input word yields zero, one or two output
// words; last_o marks the final one from a given input word. Timing: an input
// word is taken every cycle unless the input is stalled, goes through a
// one-deep input register, is parsed in a single combinational pass, and its
// results enter a four-entry output queue; an output word is valid once it
// has passed the input register and been written to the queue. The output
// port moves one word per cycle while out_stall_i is low; the input is
// stalled while a word waits in the input register and the queue has fewer
// than two free slots.
module terminal_escape_filter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       last_o
);
  import tef_pkg::*;

  // input register
  logic         in_vld_q;
  logic         kind_q;
  logic [7:0]   byte_q;
  logic         load;
  logic         adv;
  logic         room;

  // parser state
  parse_state_e state_q, state_d;
  logic         pend_q, pend_d;
  res_t         res;
  res_t         push;

  // a parsed word moves on only when the queue can take two results
  assign adv        = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= ST_GROUND;
      pend_q   <= 1'b0;
    end else begin
      if (load)     in_vld_q <= 1'b1;
      else if (adv) in_vld_q <= 1'b0;
      if (adv) begin
        state_q <= state_d;
        pend_q  <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_i;
      byte_q <= byte_in_i;
    end
  end

  tef_parser u_parser (
    .kind_i    (kind_q),
    .byte_i    (byte_q),
    .state_i   (state_q),
    .pend_cr_i (pend_q),
    .state_o   (state_d),
    .pend_cr_o (pend_d),
    .res_o     (res)
  );

  always_comb begin
    push = res;
    if (!adv) push.cnt = 2'd0;
  end

  tef_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .byte_out_o  (byte_out_o),
    .last_o      (last_o)
  );

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (kind_q == KindFlush)) |=> (state_q == ST_GROUND) && !pend_q)
    else $error("flush left parser state behind");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (state_q == $past(state_q)) && (pend_q == $past(pend_q)))
    else $error("parser state moved without an advancing word");

  a_pend_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && pend_d) |-> (kind_q == KindData) && (byte_q == ChCr))
    else $error("carriage return pending without a CR byte");

endmodule

[sim/tef_stream_compare.sv]
`timescale 1ns / 1ps

module tef_stream_compare (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       kind_i,
  input  logic [7:0] byte_in_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] byte_out_i,
  input  logic       last_i,
  output int         mismatches_o,
  output int         pending_o,
  output int         words_out_o
);
  import tef_pkg::*;

  localparam int MaxReports = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  // filter state as the block should hold it
  parse_state_e state_q;
  logic         cr_held_q;

  // words made by the current input word, then the store of words still owed
  logic [7:0]   made_ch [2];
  int           made_n;
  out_word_t    filtered_q [$];

  int           mismatches;
  int           words_out;

  function automatic void emit(input logic [7:0] ch);
    made_ch[made_n] = ch;
    made_n++;
  endfunction

  function automatic void ground_byte(input logic [7:0] ch);
    if (ch == ChCr) begin
      cr_held_q = 1'b1;
    end else if (ch == ChEsc) begin
      state_q = ST_ESC;
    end else if (ch == ChLf || ch == ChTab || (ch >= ChSpace && ch <= ChTilde) ||
                 ch >= ChHigh) begin
      emit(ch);
    end
  endfunction

  function automatic void filter_word(input logic kind, input logic [7:0] ch);
    logic redo;
    redo   = 1'b0;
    made_n = 0;
    if (kind == KindFlush) begin
      if (cr_held_q) emit(ChLf);
      cr_held_q = 1'b0;
      state_q   = ST_GROUND;
      return;
    end
    if (cr_held_q) begin
      cr_held_q = 1'b0;
      emit(ChLf);
      if (ch == ChLf) return;  // CR LF collapses to one LF
    end
    case (state_q)
      ST_ESC: begin
        if (ch == ChCsi) state_q = ST_CSI;
        else if (ch == ChOsc) state_q = ST_OSC;
        else if (ch >= ChSpace && ch <= ChIntHi) state_q = ST_ESC_INT;
        else if (ch >= ChFinLo && ch <= ChTilde) state_q = ST_GROUND;
        else begin
          state_q = ST_GROUND;
          redo    = 1'b1;
        end
      end
      ST_ESC_INT: begin
        if (ch >= ChFinLo && ch <= ChTilde) begin
          state_q = ST_GROUND;
        end else if (!(ch >= ChSpace && ch <= ChIntHi)) begin
          state_q = ST_GROUND;
          redo    = 1'b1;
        end
      end
      ST_CSI: begin
        if (ch >= ChCsiLo && ch <= ChTilde) begin
          state_q = ST_GROUND;
        end else if (ch < ChSpace || ch == ChDel || ch >= ChHigh) begin
          state_q = ST_GROUND;
          redo    = 1'b1;
        end
      end
      ST_OSC: begin
        if (ch == ChBel) state_q = ST_GROUND;
        else if (ch == ChEsc) state_q = ST_OSC_ST;
      end
      ST_OSC_ST: begin
        state_q = ST_GROUND;
        if (ch != ChBslash) redo = 1'b1;
      end
      default: begin
        state_q = ST_GROUND;
        ground_byte(ch);
      end
    endcase
    // byte that broke off a sequence is taken again as plain text
    if (redo) ground_byte(ch);
  endfunction

  function automatic void predict_word(input logic kind, input logic [7:0] ch);
    out_word_t w;
    filter_word(kind, ch);
    for (int i = 0; i < made_n; i++) begin
      w.ch   = made_ch[i];
      w.last = (i == made_n - 1);
      filtered_q.push_back(w);
    end
  endfunction

  function automatic void check_word(input logic [7:0] ch, input logic last);
    out_word_t want;
    if (filtered_q.size() == 0) begin
      if (mismatches < MaxReports)
        $display("%0t: unexpected output word %0d: byte_out %02h last %0b",
                 $time, words_out, ch, last);
      mismatches++;
      return;
    end
    want = filtered_q.pop_front();
    if (ch !== want.ch || last !== want.last) begin
      if (mismatches < MaxReports)
        $display("%0t: output word %0d: byte_out exp %02h got %02h, last exp %0b got %0b",
                 $time, words_out, want.ch, ch, want.last, last);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    = ST_GROUND;
      cr_held_q  = 1'b0;
      made_n     = 0;
      filtered_q.delete();
      mismatches = 0;
      words_out  = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      words_out_o  <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_word(kind_i, byte_in_i);
      if (out_valid_i && !out_stall_i) begin
        check_word(byte_out_i, last_i);
        words_out++;
      end
      mismatches_o <= mismatches;
      pending_o    <= filtered_q.size();
      words_out_o  <= words_out;
    end
  end

endmodule

[sim/terminal_escape_filter_top_tb.sv]
`timescale 1ns / 1ps

module terminal_escape_filter_top_tb;
  import tef_pkg::*;

  localparam int RandWords  = 1825;   // random words after the directed part
  localparam int HoldAt     = 400;    // random word count at which the long hold starts
  localparam int PauseAt    = 1100;   // random word count at which the sender drains
  localparam int HoldCycles = 150;    // long receiver hold-off
  localparam int DrainLimit = 20000;  // cycles allowed for owed words to arrive
  localparam int TailCycles = 8;      // idle cycles after the final drain

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       kind      = KindData;
  logic [7:0] byte_in   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] byte_out;
  logic       last;
  logic       hold_req  = 1'b0;  // asks the receiver for its long hold-off

  int mismatches;
  int pending;
  int words_out;

  int burst_left = 0;  // words left in the sender's current burst
  int words_in   = 0;
  int flushes    = 0;
  int sequences  = 0;

  always #4 clk = ~clk;

  terminal_escape_filter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .byte_in_i   (byte_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .byte_out_o  (byte_out),
    .last_o      (last)
  );

  // Watches both channels, predicts the filtered stream and compares it.
  tef_stream_compare u_compare (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .kind_i       (kind),
    .byte_in_i    (byte_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .byte_out_i   (byte_out),
    .last_i       (last),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .words_out_o  (words_out)
  );

  // Offer one word and hold it until taken. Called just after a rising edge.
  // Between bursts valid drops for a random gap; a zero gap just joins bursts,
  // so valid is never dropped and raised in the same step.
  task automatic send_word(input logic k, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    kind     <= k;
    byte_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    words_in++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(KindData, b);
  endtask

  // Stop offering and wait until every owed word has come out (or give up).
  // The first edge lets the owed count take in the word accepted just now.
  task automatic wait_drained(input int limit);
    int n;
    n = 0;
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Ordinary text: mostly printable, with TAB, LF and high bytes mixed in.
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0:       return ChTab;
      1:       return ChLf;
      2, 3:    return 8'($urandom_range(ChHigh, 8'hFF));
      default: return 8'($urandom_range(ChSpace, ChTilde));
    endcase
  endfunction

  // OSC body: anything but the two terminators.
  function automatic logic [7:0] osc_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(ChSpace, ChTilde));
    else b = 8'($urandom_range(0, 255));
    if (b == ChBel || b == ChEsc) b = ChSpace;
    return b;
  endfunction

  // Bytes likely to break off whatever sequence is open.
  function automatic logic [7:0] break_byte();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, ChSpace - 1));
      1:       return ChDel;
      2:       return 8'($urandom_range(ChHigh, 8'hFF));
      3:       return ChCr;
      4:       return ChEsc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: changes its stall pattern after a random span (none, light,
  // heavy, periodic) and, once asked, holds off for a long stretch so the
  // output queue fills and the block stalls its input.
  initial begin : receiver
    int mode;
    int span;
    int period;
    int on_len;
    int tick;
    bit held;
    mode   = 0;
    span   = 0;
    period = 2;
    on_len = 1;
    tick   = 0;
    held   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      if (span == 0) begin
        mode   = $urandom_range(0, 3);
        span   = $urandom_range(20, 200);
        period = $urandom_range(2, 7);
        on_len = $urandom_range(1, period - 1);
      end
      span--;
      tick++;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((tick % period) < on_len);
      endcase
    end
  end

  initial begin : stimulus
    int  base;
    int  pick;
    int  n;
    bit  hold_done;
    bit  paused;
    hold_done = 1'b0;
    paused    = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed words ---
    // ESC with a final byte at the top of the range
    send_byte(ChEsc);
    send_byte(ChTilde);
    // intermediate state broken by CR; the CR is held, then released before 0xFF
    send_byte(ChEsc);
    send_byte(8'h28);
    send_byte(ChCr);
    send_byte(8'hFF);
    // CSI with a parameter, broken by a high byte which is then passed
    send_byte(ChEsc);
    send_byte(ChCsi);
    send_byte(8'h3F);
    send_byte(ChHigh);
    // OSC closed by BEL
    send_byte(ChEsc);
    send_byte(ChOsc);
    send_byte(ChBel);
    // OSC closed by ESC backslash
    send_byte(ChEsc);
    send_byte(ChOsc);
    send_byte(ChEsc);
    send_byte(ChBslash);
    // OSC string terminator broken by ESC, which opens a new escape;
    // TAB then breaks that one and is passed
    send_byte(ChEsc);
    send_byte(ChOsc);
    send_byte(ChEsc);
    send_byte(ChEsc);
    send_byte(ChTab);
    // CR LF gives one LF
    send_byte(ChCr);
    send_byte(ChLf);
    // flush releases a held CR; a second flush gives nothing
    send_byte(ChCr);
    send_word(KindFlush, 8'h00);
    send_word(KindFlush, 8'hFF);
    flushes += 2;

    // --- random words: mostly well-formed sequences, some noise ---
    base = words_in;
    while (words_in - base < RandWords) begin
      if (!hold_done && words_in - base >= HoldAt) begin
        // keep offering without gaps while the receiver holds off
        hold_req   <= 1'b1;
        burst_left = HoldCycles + 100;
        hold_done  = 1'b1;
      end
      if (!paused && words_in - base >= PauseAt) begin
        wait_drained(DrainLimit);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(text_byte());
      end else if (pick < 32) begin
        send_byte(ChCr);
        if ($urandom_range(0, 1) != 0) send_byte(ChLf);
      end else if (pick < 42) begin
        sequences++;
        send_byte(ChEsc);
        n = $urandom_range(0, 3);
        repeat (n) send_byte(8'($urandom_range(ChSpace, ChIntHi)));
        send_byte(8'($urandom_range(ChFinLo, ChTilde)));
      end else if (pick < 60) begin
        sequences++;
        send_byte(ChEsc);
        send_byte(ChCsi);
        n = $urandom_range(0, 6);
        repeat (n) send_byte(8'($urandom_range(ChSpace, ChCsiLo - 1)));
        send_byte(8'($urandom_range(ChCsiLo, ChTilde)));
      end else if (pick < 72) begin
        sequences++;
        send_byte(ChEsc);
        send_byte(ChOsc);
        n = $urandom_range(0, 8);
        repeat (n) send_byte(osc_byte());
        case ($urandom_range(0, 7))
          0: begin
            send_word(KindFlush, 8'($urandom_range(0, 255)));
            flushes++;
          end
          1, 2, 3: send_byte(ChBel);
          default: begin
            send_byte(ChEsc);
            send_byte(ChBslash);
          end
        endcase
      end else if (pick < 84) begin
        // open a sequence and break it off
        sequences++;
        send_byte(ChEsc);
        case ($urandom_range(0, 3))
          1: send_byte(8'($urandom_range(ChSpace, ChIntHi)));
          2: begin
            send_byte(ChCsi);
            n = $urandom_range(0, 3);
            repeat (n) send_byte(8'($urandom_range(ChSpace, ChCsiLo - 1)));
          end
          3: begin
            send_byte(ChOsc);
            n = $urandom_range(0, 3);
            repeat (n) send_byte(osc_byte());
            send_byte(ChEsc);
          end
          default: ;
        endcase
        send_byte(break_byte());
      end else if (pick < 95) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_word(KindFlush, 8'($urandom_range(0, 255)));
        flushes++;
      end
    end

    // --- wind down: collect every owed word, then a few idle cycles ---
    wait_drained(DrainLimit);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d input words (%0d flushes, %0d escape sequences)",
             words_in, flushes, sequences);
    $display("checked %0d filtered words, %0d still owed, %0d mismatches",
             words_out, pending, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("terminal_escape_filter_top_tb passed");
    end else begin
      $display("terminal_escape_filter_top_tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("terminal_escape_filter_top_tb failed");
    $finish;
  end

endmodule

[terminal_escape_filter_top.f]
hw/rtl/tef_pkg.sv
hw/rtl/tef_parser.sv
hw/rtl/tef_out_fifo.sv
hw/rtl/terminal_escape_filter_top.sv
sim/tef_stream_compare.sv
sim/terminal_escape_filter_top_tb.sv
